FILE: rtl/ksps_pkg.sv
package ksps_pkg;

    // Statistics limit: pixels past this count are left out of the totals
    localparam int unsigned MAX_PIXELS = 1048576;

    localparam int PIX_W = 8;
    localparam int K_W   = 16;
    localparam int KSQ_W = 2 * K_W;

    // Accumulator widths follow from the pixel limit
    localparam int CNT_W = $clog2(longint'(MAX_PIXELS) + 1);
    localparam int SUM_W = $clog2(longint'(255) * longint'(MAX_PIXELS) + 1);
    localparam int SQ_W  = $clog2(longint'(65025) * longint'(MAX_PIXELS) + 1);

    // N*Q - S^2 and the band term k^2 * (N*Q - S^2)
    localparam int VAR_W = CNT_W + SQ_W;
    localparam int RHS_W = VAR_W + KSQ_W;

    // Distance term: 65536 * (N*px - S)^2
    localparam int NP_W      = CNT_W + PIX_W;
    localparam int D_W       = NP_W;
    localparam int LHS_SHIFT = 16;
    localparam int LHS_W     = 2 * D_W + LHS_SHIFT;
    localparam int CMP_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    // Shared multiplier: A by B, B taken 16 bits a step, top chunk first
    localparam int MUL_A_W     = VAR_W;
    localparam int MUL_B_W     = (SUM_W > KSQ_W) ? SUM_W : KSQ_W;
    localparam int MUL_CHUNK_W = 16;
    localparam int MUL_CHUNKS  = (MUL_B_W + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
    localparam int MUL_B_PAD   = MUL_CHUNKS * MUL_CHUNK_W;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_PAD;
    localparam int MUL_STEP_W  = (MUL_CHUNKS > 1) ? $clog2(MUL_CHUNKS) : 1;

    // Queue between front and back; depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [K_W-1:0]   K_RESET     = 16'd512;
    localparam logic [PIX_W-1:0] MASK_INSIDE = 8'd255;
    localparam logic [PIX_W-1:0] MASK_OUTSIDE = 8'd0;

    typedef enum logic [1:0] {
        ITEM_STAT,
        ITEM_RESTART,
        ITEM_CLASSIFY
    } item_kind_t;

    typedef struct packed {
        item_kind_t       kind;
        logic [PIX_W-1:0] pixel;
    } item_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [MUL_P_W-1:0] product;
    } mul_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NQ_GO,
        ST_NQ_WAIT,
        ST_SS_GO,
        ST_SS_WAIT,
        ST_RHS_GO,
        ST_RHS_WAIT,
        ST_NP,
        ST_DIFF,
        ST_SQ,
        ST_CMP
    } back_state_t;

endpackage

FILE: rtl/k_sigma_pixel_segmentation.sv
// k-sigma segmentation of an 8-bit grey image streamed twice: mode 0 words
// build the count, sum and sum of squares (first clears them), mode 1 words
// each return mask 255 when the pixel lies strictly within k_scaled/256
// population standard deviations of the mean, else 0. Input words go into a
// two-entry queue, so the input keeps flowing while a result waits at the
// output. The back end retires one word at a time: a statistics word is
// popped in ST_IDLE, a classify word passes ST_NP, ST_DIFF, ST_SQ and
// ST_CMP, where it waits for a free output register. The first classify
// word after reset, any statistics word or a k_scaled write first rebuilds
// the band term k^2*(N*Q - S^2) on the shared 16-bit-a-step multiplier.
// Write k_scaled only while no word is in flight.
module k_sigma_pixel_segmentation
    import ksps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             mode,
    input  logic [PIX_W-1:0] pixel,
    input  logic             first,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] mask,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [K_W-1:0]   k_scaled
);

    logic      q_valid;
    item_t     q_item;
    logic      q_pop;
    mul_req_t  mul_req;
    mul_stat_t mul_stat;

    assign cfg_ready = 1'b1;

    ksps_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .pixel    (pixel),
        .first    (first),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    ksps_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .stat  (mul_stat)
    );

    ksps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid && cfg_ready),
        .k_scaled  (k_scaled),
        .mul_req   (mul_req),
        .mul_stat  (mul_stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mask      (mask)
    );

    a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

    a_mul_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    a_mul_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |=> !mul_stat.done)
        else $error("multiplier done held longer than one cycle");

    a_mask_value: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (mask == MASK_INSIDE || mask == MASK_OUTSIDE))
        else $error("mask word neither inside nor outside code");

endmodule

FILE: rtl/ksps_front.sv
module ksps_front
    import ksps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             mode,
    input  logic [PIX_W-1:0] pixel,
    input  logic             first,
    output logic             q_valid,
    output item_t            q_item,
    input  logic             q_pop
);

    item_t              queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    logic               pop;
    item_t              new_item;

    always_comb
    begin
        new_item.pixel = pixel;
        if (mode)
        begin
            new_item.kind = ITEM_CLASSIFY;
        end
        else if (first)
        begin
            new_item.kind = ITEM_RESTART;
        end
        else
        begin
            new_item.kind = ITEM_STAT;
        end
    end

    assign in_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

FILE: rtl/ksps_mul.sv
module ksps_mul
    import ksps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mul_req_t  req,
    output mul_stat_t stat
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [MUL_STEP_W-1:0]         step_reg;
    logic [MUL_A_W-1:0]            a_reg;
    logic [MUL_B_PAD-1:0]          b_reg;
    logic [MUL_P_W-1:0]            acc_reg;
    logic [MUL_P_W-1:0]            acc_next;
    logic [MUL_CHUNK_W-1:0]        chunk;
    logic [MUL_A_W+MUL_CHUNK_W-1:0] partial;

    // Horner form: shift the running sum by one chunk, add A times the next chunk
    assign chunk    = b_reg[MUL_B_PAD-1 -: MUL_CHUNK_W];
    assign partial  = a_reg * chunk;
    assign acc_next = (acc_reg << MUL_CHUNK_W) + MUL_P_W'(partial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == MUL_STEP_W'(MUL_CHUNKS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= MUL_B_PAD'(req.b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << MUL_CHUNK_W;
        end
    end

    assign stat.busy    = busy_reg;
    assign stat.done    = done_reg;
    assign stat.product = acc_reg;

endmodule

FILE: rtl/ksps_back.sv
module ksps_back
    import ksps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  item_t            q_item,
    output logic             q_pop,
    input  logic             cfg_valid,
    input  logic [K_W-1:0]   k_scaled,
    output mul_req_t         mul_req,
    input  mul_stat_t        mul_stat,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] mask
);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [SQ_W-1:0]    sq_reg;
    logic [SQ_W-1:0]    sq_next;
    logic [KSQ_W-1:0]   k_sq_reg;
    logic [KSQ_W-1:0]   k_sq_next;
    logic               dirty_reg;
    logic               dirty_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PIX_W-1:0]   mask_reg;
    logic [PIX_W-1:0]   mask_next;
    logic [PIX_W-1:0]   px_reg;
    logic [PIX_W-1:0]   px_next;
    logic [VAR_W-1:0]   var_reg;
    logic [VAR_W-1:0]   var_next;
    logic [RHS_W-1:0]   rhs_reg;
    logic [RHS_W-1:0]   rhs_next;
    logic [NP_W-1:0]    np_reg;
    logic [NP_W-1:0]    np_next;
    logic [D_W-1:0]     d_reg;
    logic [D_W-1:0]     d_next;
    logic [2*D_W-1:0]   dsq_reg;
    logic [2*D_W-1:0]   dsq_next;
    logic [VAR_W-1:0]   ss_part;
    logic [NP_W-1:0]    sum_ext;
    logic [CMP_W-1:0]   lhs_cmp;
    logic [CMP_W-1:0]   rhs_cmp;
    logic [2*PIX_W-1:0] px_sq;

    assign ss_part = mul_stat.product[VAR_W-1:0];
    assign sum_ext = NP_W'(sum_reg);
    assign lhs_cmp = CMP_W'({dsq_reg, {LHS_SHIFT{1'b0}}});
    assign rhs_cmp = CMP_W'(rhs_reg);
    assign px_sq   = (2*PIX_W)'(q_item.pixel) * (2*PIX_W)'(q_item.pixel);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        k_sq_next      = k_sq_reg;
        dirty_next     = dirty_reg;
        out_valid_next = out_valid_reg;
        mask_next      = mask_reg;
        px_next        = px_reg;
        var_next       = var_reg;
        rhs_next       = rhs_reg;
        np_next        = np_reg;
        d_next         = d_reg;
        dsq_next       = dsq_reg;
        q_pop          = 1'b0;
        mul_req        = '0;

        // drop the held word once downstream takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_item.kind)
                        ITEM_RESTART:
                        begin
                            cnt_next   = CNT_W'(1);
                            sum_next   = SUM_W'(q_item.pixel);
                            sq_next    = SQ_W'(px_sq);
                            dirty_next = 1'b1;
                        end
                        ITEM_STAT:
                        begin
                            if (cnt_reg < CNT_W'(MAX_PIXELS))
                            begin
                                cnt_next = cnt_reg + 1'b1;
                                sum_next = sum_reg + SUM_W'(q_item.pixel);
                                sq_next  = sq_reg + SQ_W'(px_sq);
                            end
                            dirty_next = 1'b1;
                        end
                        ITEM_CLASSIFY:
                        begin
                            px_next    = q_item.pixel;
                            state_next = dirty_reg ? ST_NQ_GO : ST_NP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_NQ_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(sq_reg);
                mul_req.b     = MUL_B_W'(cnt_reg);
                state_next    = ST_NQ_WAIT;
            end
            ST_NQ_WAIT:
            begin
                if (mul_stat.done)
                begin
                    var_next   = mul_stat.product[VAR_W-1:0];
                    state_next = ST_SS_GO;
                end
            end
            ST_SS_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(sum_reg);
                mul_req.b     = MUL_B_W'(sum_reg);
                state_next    = ST_SS_WAIT;
            end
            ST_SS_WAIT:
            begin
                if (mul_stat.done)
                begin
                    var_next   = (var_reg >= ss_part) ? var_reg - ss_part : '0;
                    state_next = ST_RHS_GO;
                end
            end
            ST_RHS_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_A_W'(var_reg);
                mul_req.b     = MUL_B_W'(k_sq_reg);
                state_next    = ST_RHS_WAIT;
            end
            ST_RHS_WAIT:
            begin
                if (mul_stat.done)
                begin
                    rhs_next   = mul_stat.product[RHS_W-1:0];
                    dirty_next = 1'b0;
                    state_next = ST_NP;
                end
            end
            ST_NP:
            begin
                np_next    = NP_W'(cnt_reg) * NP_W'(px_reg);
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                d_next     = (np_reg >= sum_ext) ? np_reg - sum_ext : sum_ext - np_reg;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                dsq_next   = (2*D_W)'(d_reg) * (2*D_W)'(d_reg);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    mask_next      = (lhs_cmp < rhs_cmp) ? MASK_INSIDE : MASK_OUTSIDE;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a new k invalidates the band term
        if (cfg_valid)
        begin
            k_sq_next  = KSQ_W'(k_scaled) * KSQ_W'(k_scaled);
            dirty_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            k_sq_reg      <= KSQ_W'(K_RESET) * KSQ_W'(K_RESET);
            dirty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            k_sq_reg      <= k_sq_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        px_reg   <= px_next;
        var_reg  <= var_next;
        rhs_reg  <= rhs_next;
        np_reg   <= np_next;
        d_reg    <= d_next;
        dsq_reg  <= dsq_next;
    end

    assign out_valid = out_valid_reg;
    assign mask      = mask_reg;

endmodule
